[rtl/psb_pkg.sv]
// ----------------------------------------------------------------------------
// psb_pkg
// Shared codes, widths and types for the parameter smoother bank.
// ----------------------------------------------------------------------------
package psb_pkg;

   localparam int DEFAULT_PARAM_COUNT = 64;
   localparam int CMD_W   = 3;
   localparam int INDEX_W = 6;
   localparam int VALUE_W = 32;
   localparam int COEFF_W = 17;
   localparam int KIND_W  = 2;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SET   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TICK  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

   localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHANGED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

   localparam logic [COEFF_W-1:0] COEFF_ONE = 17'd65536;
   localparam int COEFF_SHIFT = 16;
   localparam int TOL_SHIFT   = 17;

   typedef struct packed {
      logic signed [VALUE_W-1:0] cur;
      logic signed [VALUE_W-1:0] tgt;
      logic [COEFF_W-1:0]        coeff;
      logic signed [VALUE_W-1:0] lo;
      logic signed [VALUE_W-1:0] hi;
   } entry_type;

endpackage

[rtl/psb_req_if.sv]
// ----------------------------------------------------------------------------
// psb_req_if
// Command channel of the parameter smoother bank.
// ----------------------------------------------------------------------------
interface psb_req_if;
   logic                          valid;
   logic                          ready;
   logic [psb_pkg::CMD_W-1:0]     command;
   logic [psb_pkg::INDEX_W-1:0]   param_index;
   logic signed [psb_pkg::VALUE_W-1:0] value_in;
   logic signed [psb_pkg::VALUE_W-1:0] lower_limit;
   logic signed [psb_pkg::VALUE_W-1:0] upper_limit;
   logic [psb_pkg::COEFF_W-1:0]   smoothing_coeff;

   modport source (output valid, command, param_index, value_in, lower_limit,
                   upper_limit, smoothing_coeff, input ready);
   modport sink (input valid, command, param_index, value_in, lower_limit,
                 upper_limit, smoothing_coeff, output ready);
endinterface

[rtl/psb_rsp_if.sv]
// ----------------------------------------------------------------------------
// psb_rsp_if
// Result channel of the parameter smoother bank.
// ----------------------------------------------------------------------------
interface psb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [psb_pkg::KIND_W-1:0]    kind;
   logic                          accepted;
   logic [psb_pkg::INDEX_W-1:0]   entry_index;
   logic signed [psb_pkg::VALUE_W-1:0] value_out;
   logic                          last;

   modport source (output valid, kind, accepted, entry_index, value_out, last,
                   input ready);
   modport sink (input valid, kind, accepted, entry_index, value_out, last,
                 output ready);
endinterface

[rtl/parameter_smoother_bank_core.sv]
// ----------------------------------------------------------------------------
// parameter_smoother_bank_core
// Table of one-pole smoothed parameters held in a single entry memory.
// ----------------------------------------------------------------------------
// Clear, load and unknown commands finish in the idle state; set target and read
// first read the entry memory, then do the update. A tick walks every entry
// through the memory port in turn: read, multiply, round, then snap and write
// back for a valid entry, and only the read and multiply states for an invalid
// one, then a closing step; the result side can stall the write-back step and
// the closing step. Commands are taken one at a time.
module parameter_smoother_bank_core #(
   parameter int PARAM_COUNT = psb_pkg::DEFAULT_PARAM_COUNT
) (
   input logic clock,
   input logic reset,
   psb_req_if.sink   req_chan,
   psb_rsp_if.source rsp_chan
);
   import psb_pkg::*;

   localparam int ADDR_W = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PARAM_COUNT - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SET   = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_T_RD  = 3'd3;
   localparam logic [2:0] ST_T_MUL = 3'd4;
   localparam logic [2:0] ST_T_RND = 3'd5;
   localparam logic [2:0] ST_T_FIN = 3'd6;
   localparam logic [2:0] ST_T_END = 3'd7;

   entry_type mem [PARAM_COUNT];
   entry_type rdata_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   entry_type         mem_wd;

   logic [2:0] state_ff, state_in;
   logic [PARAM_COUNT-1:0] valid_ff, valid_in, nt_ff, nt_in;
   logic force_ff, force_in, ftick_ff, ftick_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic [INDEX_W-1:0] idx6_ff, idx6_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   entry_type ent_ff, ent_in;
   logic signed [50:0] prod_ff, prod_in;
   logic signed [VALUE_W-1:0] c_ff, c_in;
   logic pend_ff, pend_in;
   logic [INDEX_W-1:0] pidx_ff, pidx_in;
   logic signed [VALUE_W-1:0] pval_ff, pval_in;

   logic rv_ff;
   logic [KIND_W-1:0] rkind_ff;
   logic racc_ff, rlast_ff;
   logic [INDEX_W-1:0] ridx_ff;
   logic signed [VALUE_W-1:0] rval_ff;

   logic emit;
   logic [KIND_W-1:0] e_kind;
   logic e_acc, e_last;
   logic [INDEX_W-1:0] e_idx;
   logic signed [VALUE_W-1:0] e_val;

   logic out_free, accept, inr;
   logic signed [VALUE_W:0] diff, dsnap, abst, absd;
   logic signed [50:0] rnd, shv;
   logic signed [VALUE_W-1:0] clamped, newc;
   logic snap, list, last_e;
   logic [COEFF_W-1:0] coeff_sat;

   assign out_free = !rv_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign accept = req_chan.valid && req_chan.ready;
   assign inr = {1'b0, req_chan.param_index} < 7'(PARAM_COUNT);
   assign last_e = (cnt_ff == LAST_ADDR);

   assign rsp_chan.valid       = rv_ff;
   assign rsp_chan.kind        = rkind_ff;
   assign rsp_chan.accepted    = racc_ff;
   assign rsp_chan.entry_index = ridx_ff;
   assign rsp_chan.value_out   = rval_ff;
   assign rsp_chan.last        = rlast_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rdata_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      nt_in    = nt_ff;
      force_in = force_ff;
      ftick_in = ftick_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      idx6_in  = idx6_ff;
      val_in   = val_ff;
      ent_in   = ent_ff;
      prod_in  = prod_ff;
      c_in     = c_ff;
      pend_in  = pend_ff;
      pidx_in  = pidx_ff;
      pval_in  = pval_ff;
      rd_addr  = cnt_ff;
      mem_we   = 1'b0;
      mem_wa   = cnt_ff;
      mem_wd   = ent_ff;
      emit     = 1'b0;
      e_kind   = KIND_ACK;
      e_acc    = 1'b0;
      e_idx    = '0;
      e_val    = '0;
      e_last   = 1'b1;

      coeff_sat = (req_chan.smoothing_coeff > COEFF_ONE) ? COEFF_ONE
                                                          : req_chan.smoothing_coeff;
      diff = {rdata_ff.tgt[VALUE_W-1], rdata_ff.tgt} - {rdata_ff.cur[VALUE_W-1], rdata_ff.cur};
      rnd  = prod_ff + (prod_ff[50] ? 51'sd32767 : 51'sd32768);
      shv  = rnd >>> COEFF_SHIFT;
      clamped = (val_ff < rdata_ff.lo) ? rdata_ff.lo :
                (val_ff > rdata_ff.hi) ? rdata_ff.hi : val_ff;
      dsnap = {ent_ff.tgt[VALUE_W-1], ent_ff.tgt} - {c_ff[VALUE_W-1], c_ff};
      absd  = dsnap[VALUE_W] ? -dsnap : dsnap;
      abst  = ent_ff.tgt[VALUE_W-1] ? -{1'b1, ent_ff.tgt} : {1'b0, ent_ff.tgt};
      snap  = !ftick_ff && ($unsigned(absd) <= (($unsigned(abst) >> TOL_SHIFT) + 33'd1));
      newc  = snap ? ent_ff.tgt : c_ff;
      if (ent_ff.coeff[COEFF_W-1]) list = ftick_ff || nt_ff[cnt_ff];
      else list = ftick_ff || nt_ff[cnt_ff] || (newc != ent_ff.cur);

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = req_chan.param_index[ADDR_W-1:0];
            if (accept) begin
               idx_in  = req_chan.param_index[ADDR_W-1:0];
               idx6_in = req_chan.param_index;
               val_in  = req_chan.value_in;
               unique case (req_chan.command)
                  CMD_CLEAR: begin
                     valid_in = '0;
                     nt_in    = '0;
                     force_in = 1'b1;
                     emit = 1'b1;
                     e_acc = 1'b1;
                  end
                  CMD_LOAD: begin
                     emit = 1'b1;
                     if (inr) begin
                        mem_we = 1'b1;
                        mem_wa = req_chan.param_index[ADDR_W-1:0];
                        mem_wd = '{cur: req_chan.value_in, tgt: req_chan.value_in,
                                   coeff: coeff_sat, lo: req_chan.lower_limit,
                                   hi: req_chan.upper_limit};
                        valid_in[req_chan.param_index[ADDR_W-1:0]] = 1'b1;
                        nt_in[req_chan.param_index[ADDR_W-1:0]]    = 1'b0;
                        force_in = 1'b1;
                        e_acc = 1'b1;
                     end
                  end
                  CMD_SET: begin
                     if (inr && valid_ff[req_chan.param_index[ADDR_W-1:0]])
                        state_in = ST_SET;
                     else
                        emit = 1'b1;
                  end
                  CMD_READ: begin
                     if (inr && valid_ff[req_chan.param_index[ADDR_W-1:0]]) begin
                        state_in = ST_READ;
                     end else begin
                        emit = 1'b1;
                        e_kind = KIND_READ;
                        e_idx = req_chan.param_index;
                     end
                  end
                  CMD_TICK: begin
                     ftick_in = force_ff;
                     force_in = 1'b0;
                     cnt_in   = '0;
                     pend_in  = 1'b0;
                     state_in = ST_T_RD;
                  end
                  default: emit = 1'b1;
               endcase
            end
         end
         ST_SET: begin
            mem_we = 1'b1;
            mem_wa = idx_ff;
            mem_wd = rdata_ff;
            mem_wd.tgt = clamped;
            if (rdata_ff.coeff[COEFF_W-1]) mem_wd.cur = clamped;
            nt_in[idx_ff] = 1'b1;
            emit = 1'b1;
            e_acc = 1'b1;
            state_in = ST_IDLE;
         end
         ST_READ: begin
            emit = 1'b1;
            e_kind = KIND_READ;
            e_acc = 1'b1;
            e_idx = idx6_ff;
            e_val = rdata_ff.cur;
            state_in = ST_IDLE;
         end
         ST_T_RD: state_in = ST_T_MUL;
         ST_T_MUL: begin
            ent_in  = rdata_ff;
            prod_in = diff * $signed({1'b0, rdata_ff.coeff});
            if (valid_ff[cnt_ff]) begin
               state_in = ST_T_RND;
            end else if (last_e) begin
               state_in = ST_T_END;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               state_in = ST_T_RD;
            end
         end
         ST_T_RND: begin
            c_in = ent_ff.cur + shv[VALUE_W-1:0];
            state_in = ST_T_FIN;
         end
         ST_T_FIN: begin
            if (!(list && pend_ff && !out_free)) begin
               if (!ent_ff.coeff[COEFF_W-1]) begin
                  mem_we = 1'b1;
                  mem_wd.cur = newc;
               end
               if (list) begin
                  if (pend_ff) begin
                     emit = 1'b1;
                     e_kind = KIND_CHANGED;
                     e_acc = 1'b1;
                     e_idx = pidx_ff;
                     e_val = pval_ff;
                     e_last = 1'b0;
                  end
                  pend_in = 1'b1;
                  pidx_in = INDEX_W'(cnt_ff);
                  pval_in = ent_ff.coeff[COEFF_W-1] ? ent_ff.cur : newc;
               end
               if (last_e) begin
                  state_in = ST_T_END;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
                  state_in = ST_T_RD;
               end
            end
         end
         ST_T_END: begin
            if (out_free) begin
               emit = 1'b1;
               if (pend_ff) begin
                  e_kind = KIND_CHANGED;
                  e_acc = 1'b1;
                  e_idx = pidx_ff;
                  e_val = pval_ff;
               end else begin
                  e_kind = KIND_NONE;
               end
               nt_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         nt_ff    <= '0;
         force_ff <= 1'b1;
         ftick_ff <= 1'b0;
         pend_ff  <= 1'b0;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         nt_ff    <= nt_in;
         force_ff <= force_in;
         ftick_ff <= ftick_in;
         pend_ff  <= pend_in;
         cnt_ff   <= cnt_in;
         if (emit) rv_ff <= 1'b1;
         else if (rsp_chan.ready) rv_ff <= 1'b0;
      end
      idx_ff  <= idx_in;
      idx6_ff <= idx6_in;
      val_ff  <= val_in;
      ent_ff  <= ent_in;
      prod_ff <= prod_in;
      c_ff    <= c_in;
      pidx_ff <= pidx_in;
      pval_ff <= pval_in;
      if (emit) begin
         rkind_ff <= e_kind;
         racc_ff  <= e_acc;
         ridx_ff  <= e_idx;
         rval_ff  <= e_val;
         rlast_ff <= e_last;
      end
   end

endmodule

[rtl/psb_checker.sv]
// ----------------------------------------------------------------------------
// psb_checker
// Port-level checks on the result channel of the smoother bank.
// ----------------------------------------------------------------------------
module psb_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [psb_pkg::KIND_W-1:0] rsp_kind,
   input logic rsp_accepted,
   input logic [psb_pkg::VALUE_W-1:0] rsp_value,
   input logic rsp_last
);
   import psb_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_CHANGED |-> rsp_last)
      else $error("single result without last");

   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_NONE |-> !rsp_accepted && rsp_value == '0)
      else $error("empty tick result malformed");

   a_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_CHANGED |-> rsp_accepted)
      else $error("changed entry not accepted");

endmodule

bind parameter_smoother_bank_core psb_checker u_psb_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_kind(rsp_chan.kind),
   .rsp_accepted(rsp_chan.accepted),
   .rsp_value(rsp_chan.value_out),
   .rsp_last(rsp_chan.last)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the parameter smoother bank.
// Commands go in through the request channel with random gaps. Results are
// checked field by field against a predictor of the entry table kept in a
// small scoreboard. The response side stalls at random. Directed items cover
// the open cases, then a random mix of load, set, tick, read, clear and unknown commands follows.
// ----------------------------------------------------------------------------
import psb_pkg::*;

typedef struct packed {
   logic [KIND_W-1:0]         kind;
   logic                      accepted;
   logic [INDEX_W-1:0]        entry_index;
   logic signed [VALUE_W-1:0] value_out;
   logic                      last;
} smoother_result_type;

class smoother_scoreboard;
   bit                   valid_mark [64];
   logic signed [31:0]   cur_val [64];
   logic signed [31:0]   tgt_val [64];
   logic [16:0]          alpha [64];
   logic signed [31:0]   lo_lim [64];
   logic signed [31:0]   hi_lim [64];
   bit                   new_tgt [64];
   bit                   force_list;
   smoother_result_type  pending_results [$];
   int                   errors;
   int                   checked;
   int                   ticks;

   function new();
      foreach (valid_mark[i]) begin
         valid_mark[i] = 0;
         new_tgt[i] = 0;
      end
      force_list = 1;
      errors = 0;
      checked = 0;
      ticks = 0;
   endfunction

   function void push(logic [1:0] k, logic a, logic [5:0] ix, logic signed [31:0] v,
                      logic l);
      smoother_result_type r;
      r.kind = k;
      r.accepted = a;
      r.entry_index = ix;
      r.value_out = v;
      r.last = l;
      pending_results.push_back(r);
   endfunction

   function logic signed [31:0] smooth_step(logic signed [31:0] c, logic signed [31:0] t,
                                            logic [16:0] a);
      longint diff, prod, mag, q;
      diff = longint'(t) - longint'(c);
      prod = diff * longint'({15'd0, a});
      mag = (prod < 0) ? -prod : prod;
      q = (mag + (64'sd1 <<< (COEFF_SHIFT - 1))) >>> COEFF_SHIFT;
      if (prod < 0) q = -q;
      return 32'(longint'(c) + q);
   endfunction

   function void note_command(logic [2:0] cmd, logic [5:0] ix, logic signed [31:0] v,
                              logic signed [31:0] lo, logic signed [31:0] hi,
                              logic [16:0] co);
      int n;
      bit fl, lst;
      logic signed [31:0] prev_val, c, vc;
      longint d, tol, t;
      n = 0;
      case (cmd)
         CMD_CLEAR: begin
            foreach (valid_mark[i]) begin
               valid_mark[i] = 0;
               new_tgt[i] = 0;
            end
            force_list = 1;
            push(KIND_ACK, 1, 0, 0, 1);
         end
         CMD_LOAD: begin
            valid_mark[ix] = 1;
            cur_val[ix] = v;
            tgt_val[ix] = v;
            lo_lim[ix] = lo;
            hi_lim[ix] = hi;
            alpha[ix] = (co > COEFF_ONE) ? COEFF_ONE : co;
            new_tgt[ix] = 0;
            force_list = 1;
            push(KIND_ACK, 1, 0, 0, 1);
         end
         CMD_SET: begin
            if (!valid_mark[ix]) begin
               push(KIND_ACK, 0, 0, 0, 1);
            end else begin
               vc = v;
               if (vc < lo_lim[ix]) vc = lo_lim[ix];
               else if (vc > hi_lim[ix]) vc = hi_lim[ix];
               tgt_val[ix] = vc;
               if (alpha[ix] >= COEFF_ONE) cur_val[ix] = vc;
               new_tgt[ix] = 1;
               push(KIND_ACK, 1, 0, 0, 1);
            end
         end
         CMD_TICK: begin
            ticks++;
            fl = force_list;
            force_list = 0;
            for (int i = 0; i < 64; i++) begin
               if (valid_mark[i]) begin
                  if (alpha[i] >= COEFF_ONE) begin
                     lst = fl || new_tgt[i];
                  end else begin
                     prev_val = cur_val[i];
                     c = smooth_step(prev_val, tgt_val[i], alpha[i]);
                     if (!fl) begin
                        t = longint'(tgt_val[i]);
                        d = t - longint'(c);
                        if (d < 0) d = -d;
                        tol = ((t < 0 ? -t : t) >>> TOL_SHIFT) + 1;
                        if (d <= tol) c = tgt_val[i];
                     end
                     cur_val[i] = c;
                     lst = fl || new_tgt[i] || (c != prev_val);
                  end
                  if (lst) begin
                     push(KIND_CHANGED, 1, 6'(i), cur_val[i], 0);
                     n++;
                  end
               end
               new_tgt[i] = 0;
            end
            if (n == 0) push(KIND_NONE, 0, 0, 0, 1);
            else pending_results[$].last = 1;
         end
         CMD_READ: begin
            if (valid_mark[ix]) push(KIND_READ, 1, ix, cur_val[ix], 1);
            else push(KIND_READ, 0, ix, 0, 1);
         end
         default: push(KIND_ACK, 0, 0, 0, 1);
      endcase
   endfunction

   function void check_result(smoother_result_type got);
      smoother_result_type exp_r;
      checked++;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result kind=%0d idx=%0d val=%h", $time, got.kind,
                  got.entry_index, got.value_out);
         errors++;
         return;
      end
      exp_r = pending_results.pop_front();
      if (got.kind !== exp_r.kind) begin
         $display("%0t: kind exp %0d got %0d", $time, exp_r.kind, got.kind);
         errors++;
      end
      if (got.accepted !== exp_r.accepted) begin
         $display("%0t: accepted exp %0d got %0d", $time, exp_r.accepted, got.accepted);
         errors++;
      end
      if (got.entry_index !== exp_r.entry_index) begin
         $display("%0t: entry_index exp %0d got %0d", $time, exp_r.entry_index,
                  got.entry_index);
         errors++;
      end
      if (got.value_out !== exp_r.value_out) begin
         $display("%0t: value_out exp %h got %h", $time, exp_r.value_out, got.value_out);
         errors++;
      end
      if (got.last !== exp_r.last) begin
         $display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last);
         errors++;
      end
   endfunction
endclass

module tb_top;
   logic clock;
   logic reset;
   int   cycles;
   int   items_sent;
   bit   send_quiet;
   bit   recv_quiet;
   smoother_scoreboard  sb;
   smoother_result_type got;

   psb_req_if req_chan ();
   psb_rsp_if rsp_chan ();

   parameter_smoother_bank_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      sb = new();
      req_chan.valid = 0;
      req_chan.command = CMD_CLEAR;
      req_chan.param_index = 0;
      req_chan.value_in = 0;
      req_chan.lower_limit = 0;
      req_chan.upper_limit = 0;
      req_chan.smoothing_coeff = 0;
      rsp_chan.ready = 0;
      cycles = 0;
      items_sent = 0;
      send_quiet = 0;
      recv_quiet = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_command(req_chan.command, req_chan.param_index, req_chan.value_in,
                            req_chan.lower_limit, req_chan.upper_limit,
                            req_chan.smoothing_coeff);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.kind = rsp_chan.kind;
            got.accepted = rsp_chan.accepted;
            got.entry_index = rsp_chan.entry_index;
            got.value_out = rsp_chan.value_out;
            got.last = rsp_chan.last;
            sb.check_result(got);
         end
      end
      if (cycles > 1500000) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // response side: random stalls with quiet stretches
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 15) == 0) recv_quiet = !recv_quiet;
         gap = recv_quiet ? 0 : $urandom_range(0, 17);
         repeat (gap) @(negedge clock) rsp_chan.ready <= 0;
         @(negedge clock) rsp_chan.ready <= 1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   task automatic send_item(logic [2:0] cmd, logic [5:0] ix, logic signed [31:0] v,
                            logic signed [31:0] lo, logic signed [31:0] hi,
                            logic [16:0] co);
      int gap;
      if ($urandom_range(0, 15) == 0) send_quiet = !send_quiet;
      gap = send_quiet ? 0 : $urandom_range(0, 17);
      repeat (gap) @(negedge clock) req_chan.valid <= 0;
      @(negedge clock);
      req_chan.command <= cmd;
      req_chan.param_index <= ix;
      req_chan.value_in <= v;
      req_chan.lower_limit <= lo;
      req_chan.upper_limit <= hi;
      req_chan.smoothing_coeff <= co;
      req_chan.valid <= 1;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic send_cmd(logic [2:0] cmd, logic [5:0] ix, logic signed [31:0] v);
      send_item(cmd, ix, v, $urandom, $urandom, 17'($urandom));
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom;
         default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      endcase
   endfunction

   function automatic logic [16:0] pick_coeff();
      case ($urandom_range(0, 7))
         0: return COEFF_ONE;
         1: return 0;
         2: return 17'($urandom);
         default: return 17'($urandom_range(1000, 40000));
      endcase
   endfunction

   initial begin
      logic [5:0] ix;
      logic signed [31:0] lo, hi;
      int sel;
      reset = 1;
      repeat (8) @(posedge clock);
      reset <= 0;

      send_cmd(CMD_CLEAR, 0, 0);
      send_cmd(CMD_TICK, 0, 0);
      send_cmd(CMD_READ, 6'd63, 0);
      send_cmd(CMD_SET, 6'd5, 100);
      send_cmd(3'd5, 6'd1, 0);
      send_cmd(3'd6, 6'd2, 0);
      send_cmd(3'd7, 6'd63, 32'h7FFF_FFFF);
      send_item(CMD_LOAD, 6'd0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, COEFF_ONE);
      send_item(CMD_LOAD, 6'd63, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 17'd0);
      send_item(CMD_LOAD, 6'd1, 0, -32'sd65536, 32'sd65536, 17'h1FFFF);
      send_item(CMD_LOAD, 6'd2, 0, 32'sd1000, -32'sd1000, 17'd1);
      send_item(CMD_LOAD, 6'd3, 32'sd100000, 32'h8000_0000, 32'h7FFF_FFFF, 17'd32768);
      send_cmd(CMD_TICK, 0, 0);
      send_cmd(CMD_SET, 6'd1, 32'h7FFF_FFFF);
      send_cmd(CMD_SET, 6'd2, -32'sd5000);
      send_cmd(CMD_SET, 6'd3, 32'h8000_0000);
      send_cmd(CMD_SET, 6'd63, 32'h7FFF_FFF0);
      send_cmd(CMD_TICK, 0, 0);
      send_cmd(CMD_TICK, 0, 0);
      send_cmd(CMD_TICK, 0, 0);
      send_cmd(CMD_READ, 6'd3, 0);
      send_cmd(CMD_READ, 6'd0, 0);
      send_cmd(CMD_TICK, 0, 0);

      repeat (270) begin
         sel = $urandom_range(0, 99);
         ix = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
         if (sel < 20) begin
            lo = pick_value();
            hi = pick_value();
            if ($urandom_range(0, 3) != 0 && lo > hi) begin
               lo = lo ^ hi; hi = lo ^ hi; lo = lo ^ hi;
            end
            send_item(CMD_LOAD, ix, pick_value(), lo, hi, pick_coeff());
         end else if (sel < 50) begin
            send_cmd(CMD_SET, ix, pick_value());
         end else if (sel < 75) begin
            send_cmd(CMD_TICK, 6'($urandom), $urandom);
         end else if (sel < 93) begin
            send_cmd(CMD_READ, ix, $urandom);
         end else if (sel < 96) begin
            send_cmd(CMD_CLEAR, 6'($urandom), $urandom);
         end else begin
            send_cmd(3'($urandom_range(5, 7)), 6'($urandom), $urandom);
         end
      end

      @(negedge clock) req_chan.valid <= 0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Sent %0d items, checked %0d results across %0d ticks.", items_sent,
               sb.checked, sb.ticks);
      if (sb.errors == 0 && sb.pending_results.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end
endmodule
